/* rtl/assert_macros.svh */
// Assertion macros used by the RTL top level to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/usbets_pkg.sv */
// Types, codes and helpers of the USB endpoint transfer sequencer.
package usbets_pkg;

    typedef enum logic [2:0] {
        FUNC_OUT_RX      = 3'd0,
        FUNC_IN_DONE     = 3'd1,
        FUNC_ARM_READ    = 3'd2,
        FUNC_START_WRITE = 3'd3,
        FUNC_SEND_STATUS = 3'd4,
        FUNC_SETUP       = 3'd5
    } t_func;

    typedef enum logic [1:0] {
        COPY_NONE    = 2'd0,
        COPY_TO_USER = 2'd1,
        COPY_TO_PMA  = 2'd2
    } t_copy_dir;

    typedef enum logic [1:0] {
        STAT_NONE  = 2'd0,
        STAT_VALID = 2'd1,
        STAT_STALL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        NOTE_NONE      = 3'd0,
        NOTE_SETUP     = 3'd1,
        NOTE_OUT_DONE  = 3'd2,
        NOTE_IN_DONE   = 3'd3,
        NOTE_CTRL_DONE = 3'd4,
        NOTE_CTRL_ERR  = 3'd5
    } t_notify;

    // Endpoint-0 control stage, one-hot.
    typedef enum logic [7:0] {
        ST_WAIT_SETUP    = 8'b0000_0001,
        ST_SETTING_UP    = 8'b0000_0010,
        ST_IN_DATA       = 8'b0000_0100,
        ST_OUT_DATA      = 8'b0000_1000,
        ST_LAST_IN       = 8'b0001_0000,
        ST_WAIT_STAT_IN  = 8'b0010_0000,
        ST_WAIT_STAT_OUT = 8'b0100_0000,
        ST_STALLED       = 8'b1000_0000
    } t_stage;

    localparam logic [2:0] CODE_WAIT_SETUP    = 3'd0;
    localparam logic [2:0] CODE_SETTING_UP    = 3'd1;
    localparam logic [2:0] CODE_IN_DATA       = 3'd2;
    localparam logic [2:0] CODE_OUT_DATA      = 3'd3;
    localparam logic [2:0] CODE_LAST_IN       = 3'd4;
    localparam logic [2:0] CODE_WAIT_STAT_IN  = 3'd5;
    localparam logic [2:0] CODE_WAIT_STAT_OUT = 3'd6;
    localparam logic [2:0] CODE_STALLED       = 3'd7;

    typedef struct packed {
        t_func       func;
        logic [2:0]  endpoint;
        logic [6:0]  rx_count;
        logic [15:0] transfer_length;
    } t_in_item;

    typedef struct packed {
        t_copy_dir   copy_dir;
        logic [15:0] copy_offset;
        logic [6:0]  copy_length;
        logic        rx_count_write;
        logic [6:0]  rx_count_value;
        logic        tx_count_write;
        logic [6:0]  tx_count_value;
        t_status     rx_status;
        t_status     tx_status;
        t_notify     notify;
        logic [15:0] notify_size;
        logic [2:0]  control_state;
    } t_out_item;

    // Descriptor write-back from the step logic to the endpoint registers.
    typedef struct packed {
        logic        in_we;
        logic [15:0] in_left;
        logic [15:0] in_done;
        logic        out_we;
        logic [15:0] out_left;
        logic [15:0] out_done;
    } t_desc_upd;

    function automatic logic [2:0] stage_code(input t_stage stage);
        logic [2:0] code;
        code = CODE_WAIT_SETUP;
        unique case (stage)
            ST_WAIT_SETUP:    code = CODE_WAIT_SETUP;
            ST_SETTING_UP:    code = CODE_SETTING_UP;
            ST_IN_DATA:       code = CODE_IN_DATA;
            ST_OUT_DATA:      code = CODE_OUT_DATA;
            ST_LAST_IN:       code = CODE_LAST_IN;
            ST_WAIT_STAT_IN:  code = CODE_WAIT_STAT_IN;
            ST_WAIT_STAT_OUT: code = CODE_WAIT_STAT_OUT;
            ST_STALLED:       code = CODE_STALLED;
            default:          code = CODE_WAIT_SETUP;
        endcase
        return code;
    endfunction

endpackage

/* rtl/usbets_in_if.sv */
// Event channel: valid/ready handshake carrying one event item.
interface usbets_in_if;
    logic                valid;
    logic                ready;
    usbets_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/usbets_out_if.sv */
// Result channel: valid/ready handshake carrying one result item.
interface usbets_out_if;
    logic                 valid;
    logic                 ready;
    usbets_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/usb_endpoint_transfer_sequencer_unit.sv */
// Top level of the USB endpoint transfer sequencer.
//
//  channel | dir | payload         | transaction
//  --------+-----+-----------------+-----------------------------------
//  i_in    | in  | t_in_item       | one endpoint event
//  o_out   | out | t_out_item      | one result per event
//
// An accepted event is held in the input register; the descriptor
// read-modify-write and stage update then happen while the result register
// loads. Throughput is one event a cycle while results are being taken.
// Reset (synchronous, active low) clears the control stage to wait for
// setup and all endpoint descriptors to zero; no clearing pass.
// A stalled result holds the result register; the input register still
// takes one more event, then i_in.ready drops until the result is taken.
`include "assert_macros.svh"

module usb_endpoint_transfer_sequencer_unit #(
    parameter int NUM_ENDPOINTS = 8,
    parameter int MAX_PACKET    = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    usbets_in_if.sink     i_in,
    usbets_out_if.source  o_out
);
    import usbets_pkg::*;

    // Descriptor index width; the event field is 3 bits, zero-extended to 4.
    localparam int EpW = (NUM_ENDPOINTS > 1) ? $clog2(NUM_ENDPOINTS) : 1;

    // Input register.
    logic      r_in_valid;
    t_in_item  r_in;

    // Result register.
    logic      r_out_valid;
    t_out_item r_out;

    // Control stage and per-endpoint descriptors.
    t_stage      r_stage;
    logic [15:0] r_in_left  [NUM_ENDPOINTS];
    logic [15:0] r_in_done  [NUM_ENDPOINTS];
    logic [15:0] r_out_left [NUM_ENDPOINTS];
    logic [15:0] r_out_done [NUM_ENDPOINTS];

    logic           adv;
    logic           take;
    logic [3:0]     ep4;
    logic           ep_ok;
    logic [EpW-1:0] idx;
    t_desc_upd      upd;
    t_stage         n_stage;
    t_out_item      n_out;

    // Result register frees up when empty or drained this cycle.
    assign adv  = !r_out_valid || o_out.ready;
    assign take = r_in_valid && adv;

    assign i_in.ready  = i_rst_n && (!r_in_valid || adv);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Send status always targets endpoint 0; out-of-range reads park on 0.
    assign ep4   = {1'b0, r_in.endpoint};
    assign ep_ok = {1'b0, ep4} < 5'(NUM_ENDPOINTS);
    assign idx   = ((r_in.func == FUNC_SEND_STATUS) || !ep_ok) ? '0 : ep4[EpW-1:0];

    usbets_step #(
        .MAX_PACKET (MAX_PACKET)
    ) u_step (
        .i_func     (r_in.func),
        .i_ep_ok    (ep_ok),
        .i_ep_zero  (r_in.endpoint == 3'd0),
        .i_rx_count (r_in.rx_count),
        .i_length   (r_in.transfer_length),
        .i_in_left  (r_in_left[idx]),
        .i_in_done  (r_in_done[idx]),
        .i_out_left (r_out_left[idx]),
        .i_out_done (r_out_done[idx]),
        .i_stage    (r_stage),
        .o_upd      (upd),
        .o_stage    (n_stage),
        .o_result   (n_out)
    );

    // Control state: handshake flags, stage, descriptors.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_stage     <= ST_WAIT_SETUP;
            for (int e = 0; e < NUM_ENDPOINTS; e++) begin
                r_in_left[e]  <= 16'd0;
                r_in_done[e]  <= 16'd0;
                r_out_left[e] <= 16'd0;
                r_out_done[e] <= 16'd0;
            end
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (take) begin
                r_in_valid <= 1'b0;
            end

            if (take) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (take) begin
                r_stage <= n_stage;
                if (upd.in_we) begin
                    r_in_left[idx] <= upd.in_left;
                    r_in_done[idx] <= upd.in_done;
                end
                if (upd.out_we) begin
                    r_out_left[idx] <= upd.out_left;
                    r_out_done[idx] <= upd.out_done;
                end
            end
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
        if (take) begin
            r_out <= n_out;
        end
    end

    // Input register full behind a stalled result must back-pressure.
    `ASSERT_IMPLIES(a_backpressure, r_in_valid && r_out_valid && !o_out.ready, !i_in.ready, "input accepted while both stages are stalled")
    // A setup event always lands the control stage in setting up.
    `ASSERT_NEXT(a_setup_stage, take && (r_in.func == FUNC_SETUP), r_stage == ST_SETTING_UP, "setup did not move control stage")
    // A transmit count written never exceeds one packet.
    `ASSERT_IMPLIES(a_tx_count_max, o_out.valid && o_out.data.tx_count_write, o_out.data.tx_count_value <= 7'(MAX_PACKET), "tx count above packet size")

endmodule

/* rtl/usbets_step.sv */
// Per-event step logic: descriptor update, control stage and result item.
module usbets_step #(
    parameter int MAX_PACKET = 64
) (
    input  usbets_pkg::t_func     i_func,
    input  logic                  i_ep_ok,
    input  logic                  i_ep_zero,
    input  logic [6:0]            i_rx_count,
    input  logic [15:0]           i_length,
    input  logic [15:0]           i_in_left,
    input  logic [15:0]           i_in_done,
    input  logic [15:0]           i_out_left,
    input  logic [15:0]           i_out_done,
    input  usbets_pkg::t_stage    i_stage,
    output usbets_pkg::t_desc_upd o_upd,
    output usbets_pkg::t_stage    o_stage,
    output usbets_pkg::t_out_item o_result
);
    import usbets_pkg::*;

    localparam logic [6:0]  MaxPkt7  = 7'(MAX_PACKET);
    localparam logic [15:0] MaxPkt16 = 16'(MAX_PACKET);

    // Bytes of the next packet out of a remaining count.
    function automatic logic [6:0] pkt_of(input logic [15:0] left);
        return (left >= MaxPkt16) ? MaxPkt7 : left[6:0];
    endfunction

    logic [6:0]  size;
    logic [15:0] size16;
    logic [15:0] out_left_n;
    logic [15:0] out_done_n;
    t_out_item   res;

    always_comb begin
        size = (i_rx_count > MaxPkt7) ? MaxPkt7 : i_rx_count;
        if (i_func == FUNC_IN_DONE) begin
            size = pkt_of(i_in_left);
        end else if (i_func == FUNC_START_WRITE) begin
            size = pkt_of(i_length);
        end
        size16     = {9'd0, size};
        out_left_n = (i_out_left > size16) ? (i_out_left - size16) : 16'd0;
        out_done_n = i_out_done + size16;
    end

    always_comb begin
        res               = '0;
        res.copy_dir      = COPY_NONE;
        res.rx_status     = STAT_NONE;
        res.tx_status     = STAT_NONE;
        res.notify        = NOTE_NONE;
        o_upd             = '0;
        o_stage           = i_stage;

        priority case (1'b1)
            (i_func == FUNC_OUT_RX) && i_ep_ok: begin
                res.copy_dir    = COPY_TO_USER;
                res.copy_offset = i_out_done;
                res.copy_length = size;
                o_upd.out_we    = 1'b1;
                o_upd.out_left  = out_left_n;
                o_upd.out_done  = out_done_n;
                if ((out_left_n != 16'd0) && (size == MaxPkt7)) begin
                    res.rx_count_write = 1'b1;
                    res.rx_count_value = pkt_of(out_left_n);
                    res.rx_status      = STAT_VALID;
                end else if (i_ep_zero) begin
                    if (i_stage == ST_WAIT_STAT_OUT) begin
                        o_stage            = ST_STALLED;
                        res.rx_count_write = 1'b1;
                        res.rx_count_value = MaxPkt7;
                        res.rx_status      = STAT_STALL;
                        res.tx_status      = STAT_STALL;
                    end else if (i_stage == ST_OUT_DATA) begin
                        o_stage            = ST_WAIT_STAT_IN;
                        res.tx_count_write = 1'b1;
                        res.tx_status      = STAT_VALID;
                    end else begin
                        res.notify = NOTE_CTRL_ERR;
                    end
                end else begin
                    res.notify      = NOTE_OUT_DONE;
                    res.notify_size = out_done_n;
                end
            end
            (i_func == FUNC_IN_DONE) && i_ep_ok: begin
                if (i_in_left == 16'd0) begin
                    if (i_ep_zero) begin
                        if (i_stage == ST_IN_DATA) begin
                            o_stage            = ST_LAST_IN;
                            res.tx_count_write = 1'b1;
                            res.tx_status      = STAT_VALID;
                        end else if (i_stage == ST_LAST_IN) begin
                            o_stage       = ST_WAIT_STAT_OUT;
                            res.tx_status = STAT_STALL;
                        end else if (i_stage == ST_WAIT_STAT_IN) begin
                            o_stage            = ST_STALLED;
                            res.rx_count_write = 1'b1;
                            res.rx_count_value = MaxPkt7;
                            res.rx_status      = STAT_STALL;
                            res.tx_status      = STAT_STALL;
                            res.notify         = NOTE_CTRL_DONE;
                        end else begin
                            res.tx_status = STAT_STALL;
                            res.notify    = NOTE_CTRL_ERR;
                        end
                    end else begin
                        res.notify      = NOTE_IN_DONE;
                        res.notify_size = i_in_done;
                    end
                end else begin
                    if (i_ep_zero) begin
                        o_stage       = (i_in_left >= MaxPkt16) ? ST_IN_DATA : ST_LAST_IN;
                        res.rx_status = STAT_VALID;
                    end
                    res.copy_dir       = COPY_TO_PMA;
                    res.copy_offset    = i_in_done;
                    res.copy_length    = size;
                    o_upd.in_we        = 1'b1;
                    o_upd.in_left      = i_in_left - size16;
                    o_upd.in_done      = i_in_done + size16;
                    res.tx_count_write = 1'b1;
                    res.tx_count_value = size;
                    res.tx_status      = STAT_VALID;
                end
            end
            (i_func == FUNC_ARM_READ) && i_ep_ok: begin
                o_upd.out_we       = 1'b1;
                o_upd.out_left     = i_length;
                o_upd.out_done     = 16'd0;
                if (i_ep_zero) begin
                    o_stage = ST_OUT_DATA;
                end
                res.rx_count_write = 1'b1;
                res.rx_count_value = pkt_of(i_length);
                res.rx_status      = STAT_VALID;
            end
            (i_func == FUNC_START_WRITE) && i_ep_ok: begin
                if (i_ep_zero) begin
                    if (i_length == 16'd0) begin
                        o_stage = ST_WAIT_STAT_IN;
                    end else if (i_length >= MaxPkt16) begin
                        o_stage = ST_IN_DATA;
                    end else begin
                        o_stage = ST_LAST_IN;
                    end
                    res.rx_status = STAT_VALID;
                end
                o_upd.in_we   = 1'b1;
                o_upd.in_left = i_length - size16;
                o_upd.in_done = size16;
                if (size != 7'd0) begin
                    res.copy_dir    = COPY_TO_PMA;
                    res.copy_length = size;
                end
                res.tx_count_write = 1'b1;
                res.tx_count_value = size;
                res.tx_status      = STAT_VALID;
            end
            i_func == FUNC_SEND_STATUS: begin
                o_stage            = ST_WAIT_STAT_IN;
                o_upd.in_we        = 1'b1;
                res.tx_count_write = 1'b1;
                res.tx_status      = STAT_VALID;
            end
            i_func == FUNC_SETUP: begin
                o_stage    = ST_SETTING_UP;
                res.notify = NOTE_SETUP;
            end
            default: begin
                // unused code or endpoint out of range: no action
            end
        endcase

        res.control_state = stage_code(o_stage);
        o_result          = res;
    end

endmodule

/* tb/usb_endpoint_transfer_sequencer_unit_tb.sv */
// Self-checking testbench for the USB endpoint transfer sequencer top level.
`timescale 1ns / 1ps

module usb_endpoint_transfer_sequencer_unit_tb;
    import usbets_pkg::*;

    localparam int          NUM_EPS      = 8;
    localparam logic [15:0] MAX_PKT      = 16'd64;
    localparam int          LONG_HOLD    = 300;   // receiver hold-off, cycles
    localparam int          TAIL_CYCLES  = 8;     // pipeline drain plus margin
    localparam int          PHASE_EVENTS = 300;   // random events per idle phase
    localparam int          QUEUE_DEPTH  = 8;     // events staged ahead of the driver

    // func codes the block must treat as no-ops
    localparam t_func FUNC_SPARE_6 = t_func'(3'd6);
    localparam t_func FUNC_SPARE_7 = t_func'(3'd7);

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    usbets_in_if  ev_if ();
    usbets_out_if res_if ();

    usb_endpoint_transfer_sequencer_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (ev_if),
        .o_out   (res_if)
    );

    // 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Testbench state
    // ------------------------------------------------------------------
    t_in_item   events_to_send [$];   // staged events, front is on the bus
    t_out_item  results_due [$];      // predicted results, oldest first
    int         events_made = 0;
    int         mismatches = 0;
    bit         ev_taken = 1'b0;      // event transaction at the last rising edge
    t_idle_mode idle_mode = IDLE_NONE;
    int         hold_requests = 0;    // bumped by the stimulus to ask for a hold-off
    int         hold_served = 0;
    int         hold_left = 0;

    // Shadow copy of the block's state, advanced once per accepted event.
    logic [2:0]  ctrl_stage_q = CODE_WAIT_SETUP;
    logic [15:0] in_left_q  [NUM_EPS] = '{default: '0};
    logic [15:0] in_done_q  [NUM_EPS] = '{default: '0};
    logic [15:0] out_left_q [NUM_EPS] = '{default: '0};
    logic [15:0] out_done_q [NUM_EPS] = '{default: '0};

    // Known values on every input from time zero.
    initial begin
        ev_if.valid  = 1'b0;
        ev_if.data   = '0;
        res_if.ready = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [15:0] packet_size(logic [15:0] left);
        return (left >= MAX_PKT) ? MAX_PKT : left;
    endfunction

    // Applies one event to the shadow state and returns the result it causes.
    // The 3-bit endpoint field never reaches past the last endpoint, so the
    // out-of-range case cannot arise with eight endpoints.
    function automatic t_out_item sequence_event(t_in_item ev);
        t_out_item   r;
        logic [2:0]  ep;
        logic [15:0] len;
        logic [15:0] size;
        r   = '0;
        ep  = ev.endpoint;
        len = ev.transfer_length;
        case (ev.func)
            FUNC_OUT_RX: begin
                // oversized packets are clipped to one full packet
                size = (ev.rx_count > MAX_PKT) ? MAX_PKT : 16'(ev.rx_count);
                r.copy_dir    = COPY_TO_USER;
                r.copy_offset = out_done_q[ep];
                r.copy_length = size[6:0];
                out_left_q[ep] = (out_left_q[ep] > size) ? out_left_q[ep] - size : 16'd0;
                out_done_q[ep] = out_done_q[ep] + size;
                if (out_left_q[ep] != 0 && size == MAX_PKT) begin
                    // more to come: re-arm for the next packet
                    r.rx_count_write = 1'b1;
                    r.rx_count_value = 7'(packet_size(out_left_q[ep]));
                    r.rx_status      = STAT_VALID;
                end else if (ep == 0) begin
                    if (ctrl_stage_q == CODE_WAIT_STAT_OUT) begin
                        ctrl_stage_q     = CODE_STALLED;
                        r.rx_count_write = 1'b1;
                        r.rx_count_value = MAX_PKT[6:0];
                        r.rx_status      = STAT_STALL;
                        r.tx_status      = STAT_STALL;
                    end else if (ctrl_stage_q == CODE_OUT_DATA) begin
                        ctrl_stage_q     = CODE_WAIT_STAT_IN;
                        r.tx_count_write = 1'b1;
                        r.tx_status      = STAT_VALID;
                    end else begin
                        r.notify = NOTE_CTRL_ERR;
                    end
                end else begin
                    r.notify      = NOTE_OUT_DONE;
                    r.notify_size = out_done_q[ep];
                end
            end
            FUNC_IN_DONE: begin
                if (in_left_q[ep] == 0) begin
                    if (ep == 0) begin
                        if (ctrl_stage_q == CODE_IN_DATA) begin
                            // zero-length packet closes a transfer of whole packets
                            ctrl_stage_q     = CODE_LAST_IN;
                            r.tx_count_write = 1'b1;
                            r.tx_status      = STAT_VALID;
                        end else if (ctrl_stage_q == CODE_LAST_IN) begin
                            ctrl_stage_q = CODE_WAIT_STAT_OUT;
                            r.tx_status  = STAT_STALL;
                        end else if (ctrl_stage_q == CODE_WAIT_STAT_IN) begin
                            ctrl_stage_q     = CODE_STALLED;
                            r.rx_count_write = 1'b1;
                            r.rx_count_value = MAX_PKT[6:0];
                            r.rx_status      = STAT_STALL;
                            r.tx_status      = STAT_STALL;
                            r.notify         = NOTE_CTRL_DONE;
                        end else begin
                            r.tx_status = STAT_STALL;
                            r.notify    = NOTE_CTRL_ERR;
                        end
                    end else begin
                        r.notify      = NOTE_IN_DONE;
                        r.notify_size = in_done_q[ep];
                    end
                end else begin
                    size = packet_size(in_left_q[ep]);
                    if (ep == 0) begin
                        ctrl_stage_q = (in_left_q[ep] >= MAX_PKT) ? CODE_IN_DATA : CODE_LAST_IN;
                    end
                    r.copy_dir       = COPY_TO_PMA;
                    r.copy_offset    = in_done_q[ep];
                    r.copy_length    = size[6:0];
                    in_left_q[ep]    = in_left_q[ep] - size;
                    in_done_q[ep]    = in_done_q[ep] + size;
                    r.tx_count_write = 1'b1;
                    r.tx_count_value = size[6:0];
                    r.tx_status      = STAT_VALID;
                    if (ep == 0) begin
                        r.rx_status = STAT_VALID;
                    end
                end
            end
            FUNC_ARM_READ: begin
                out_left_q[ep] = len;
                out_done_q[ep] = '0;
                if (ep == 0) begin
                    ctrl_stage_q = CODE_OUT_DATA;
                end
                r.rx_count_write = 1'b1;
                r.rx_count_value = 7'(packet_size(len));
                r.rx_status      = STAT_VALID;
            end
            FUNC_START_WRITE: begin
                if (ep == 0) begin
                    if (len == 0) begin
                        ctrl_stage_q = CODE_WAIT_STAT_IN;
                    end else if (len >= MAX_PKT) begin
                        ctrl_stage_q = CODE_IN_DATA;
                    end else begin
                        ctrl_stage_q = CODE_LAST_IN;
                    end
                    r.rx_status = STAT_VALID;
                end
                size          = packet_size(len);
                in_left_q[ep] = len - size;
                in_done_q[ep] = size;
                if (size != 0) begin
                    r.copy_dir    = COPY_TO_PMA;
                    r.copy_length = size[6:0];
                end
                r.tx_count_write = 1'b1;
                r.tx_count_value = size[6:0];
                r.tx_status      = STAT_VALID;
            end
            FUNC_SEND_STATUS: begin
                // always endpoint 0, whatever the endpoint field says
                ctrl_stage_q     = CODE_WAIT_STAT_IN;
                in_left_q[0]     = '0;
                in_done_q[0]     = '0;
                r.tx_count_write = 1'b1;
                r.tx_status      = STAT_VALID;
            end
            FUNC_SETUP: begin
                ctrl_stage_q = CODE_SETTING_UP;
                r.notify     = NOTE_SETUP;
            end
            default: begin
                // spare codes: nothing changes
            end
        endcase
        r.control_state = ctrl_stage_q;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_result(t_out_item got);
        t_out_item want;
        if (results_due.size() == 0) begin
            $error("result transaction with no event pending");
            mismatches++;
            return;
        end
        want = results_due.pop_front();
        check_field("copy_dir",       16'(want.copy_dir),       16'(got.copy_dir));
        check_field("copy_offset",    want.copy_offset,         got.copy_offset);
        check_field("copy_length",    16'(want.copy_length),    16'(got.copy_length));
        check_field("rx_count_write", 16'(want.rx_count_write), 16'(got.rx_count_write));
        check_field("rx_count_value", 16'(want.rx_count_value), 16'(got.rx_count_value));
        check_field("tx_count_write", 16'(want.tx_count_write), 16'(got.tx_count_write));
        check_field("tx_count_value", 16'(want.tx_count_value), 16'(got.tx_count_value));
        check_field("rx_status",      16'(want.rx_status),      16'(got.rx_status));
        check_field("tx_status",      16'(want.tx_status),      16'(got.tx_status));
        check_field("notify",         16'(want.notify),         16'(got.notify));
        check_field("notify_size",    want.notify_size,         got.notify_size);
        check_field("control_state",  16'(want.control_state),  16'(got.control_state));
    endfunction

    // Monitor: samples both channels at the rising edge. Events are predicted
    // in acceptance order, which is also the order results come back in.
    always @(posedge i_clk) begin
        ev_taken = 1'b0;
        if (i_rst_n) begin
            if (ev_if.valid && ev_if.ready) begin
                ev_taken = 1'b1;
                results_due.push_back(sequence_event(ev_if.data));
                void'(events_to_send.pop_front());
            end
            if (res_if.valid && res_if.ready) begin
                check_result(res_if.data);
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver and receiver, both on the falling edge
    // ------------------------------------------------------------------
    function automatic bit sender_gap();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(0, 99) < 73;
            IDLE_BOTH:   return $urandom_range(0, 99) < 11;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stall();
        case (idle_mode)
            IDLE_RECEIVER: return $urandom_range(0, 99) < 73;
            IDLE_BOTH:     return $urandom_range(0, 99) < 11;
            default:       return 1'b0;
        endcase
    endfunction

    // An offered event stays on the bus until taken; only then may a gap
    // or the next event follow.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            ev_if.valid <= 1'b0;
        end else if (!ev_if.valid || ev_taken) begin
            if (events_to_send.size() > 0 && !sender_gap()) begin
                ev_if.valid <= 1'b1;
                ev_if.data  <= events_to_send[0];
            end else begin
                ev_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls per phase, plus long hold-offs on request that
    // let the pipeline fill and push back on the event channel.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served  <= hold_requests;
            hold_left    <= LONG_HOLD;
            res_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= !receiver_stall();
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_event(t_func f, int unsigned ep, int unsigned rxc, int unsigned len);
        t_in_item ev;
        ev.func            = f;
        ev.endpoint        = ep[2:0];
        ev.rx_count        = rxc[6:0];
        ev.transfer_length = len[15:0];
        events_to_send.push_back(ev);
        events_made++;
    endtask

    function automatic int unsigned any_ep();
        return $urandom_range(0, NUM_EPS - 1);
    endfunction

    function automatic int unsigned any_rx();
        return $urandom_range(0, 127);
    endfunction

    function automatic int unsigned any_len();
        return $urandom_range(0, 65535);
    endfunction

    // Mostly short transfers, some near packet boundaries, a few full-range.
    function automatic int unsigned pick_length();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 55) return $urandom_range(0, 200);
        if (sel < 85) return 64 * $urandom_range(1, 4) - 1 + $urandom_range(0, 2);
        return any_len();
    endfunction

    // Packet size for an OUT data packet: full, now and then oversized.
    function automatic int unsigned full_rx();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(65, 127) : 64;
    endfunction

    // One well-formed transfer with random content, or a burst of noise.
    // Long transfers are cut off after a handful of packets.
    task automatic queue_sequence();
        int unsigned kind;
        int unsigned len;
        int unsigned left;
        int unsigned ep;
        int unsigned n;
        kind = $urandom_range(0, 9);
        if (kind <= 2) begin
            // control write: setup, data IN packets, status OUT
            queue_event(FUNC_SETUP, any_ep(), any_rx(), any_len());
            len = pick_length();
            queue_event(FUNC_START_WRITE, 0, any_rx(), len);
            n = len / 64 + $urandom_range(1, 2);
            if (n > 8) n = 8;
            repeat (n) queue_event(FUNC_IN_DONE, 0, any_rx(), any_len());
            if ($urandom_range(0, 3) != 0) begin
                queue_event(FUNC_OUT_RX, 0, ($urandom_range(0, 3) == 0) ? any_rx() : 0,
                            any_len());
            end else begin
                queue_event(FUNC_SEND_STATUS, any_ep(), any_rx(), any_len());
            end
        end else if (kind <= 4) begin
            // control read: setup, data OUT packets, status IN
            queue_event(FUNC_SETUP, any_ep(), any_rx(), any_len());
            len = pick_length();
            queue_event(FUNC_ARM_READ, 0, any_rx(), len);
            left = len;
            n = 0;
            while (left >= 64 && n < 8) begin
                queue_event(FUNC_OUT_RX, 0, full_rx(), any_len());
                left -= 64;
                n++;
            end
            queue_event(FUNC_OUT_RX, 0, (left < 64) ? left : $urandom_range(0, 63), any_len());
            if ($urandom_range(0, 4) == 0) begin
                queue_event(FUNC_SEND_STATUS, any_ep(), any_rx(), any_len());
            end
            repeat ($urandom_range(1, 2)) queue_event(FUNC_IN_DONE, 0, any_rx(), any_len());
        end else if (kind <= 6) begin
            // bulk IN on a data endpoint
            ep  = $urandom_range(1, NUM_EPS - 1);
            len = pick_length();
            queue_event(FUNC_START_WRITE, ep, any_rx(), len);
            n = len / 64 + $urandom_range(1, 2);
            if (n > 8) n = 8;
            repeat (n) queue_event(FUNC_IN_DONE, ep, any_rx(), any_len());
        end else if (kind <= 8) begin
            // bulk OUT on a data endpoint
            ep  = $urandom_range(1, NUM_EPS - 1);
            len = pick_length();
            queue_event(FUNC_ARM_READ, ep, any_rx(), len);
            left = len;
            n = 0;
            while (left >= 64 && n < 8) begin
                queue_event(FUNC_OUT_RX, ep, full_rx(), any_len());
                left -= 64;
                n++;
            end
            queue_event(FUNC_OUT_RX, ep, (left < 64) ? left : $urandom_range(0, 63), any_len());
        end else begin
            // noise: any code, any endpoint, any field values
            repeat ($urandom_range(1, 4)) begin
                queue_event(t_func'($urandom_range(0, 7)), any_ep(), any_rx(), any_len());
            end
        end
    endtask

    task automatic wait_drained();
        while (events_to_send.size() > 0 || results_due.size() > 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int target;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: stage errors from reset, a control write that ends in a
        // short packet, one of whole packets closed by a zero-length packet,
        // a control read with an oversized packet, status and zero-length
        // writes, full-range lengths on data endpoints, spare codes.
        queue_event(FUNC_IN_DONE,     0, 0,   0);
        queue_event(FUNC_OUT_RX,      0, 0,   0);
        queue_event(FUNC_SETUP,       7, 127, 16'hFFFF);
        queue_event(FUNC_START_WRITE, 0, 0,   100);
        queue_event(FUNC_IN_DONE,     0, 0,   0);
        queue_event(FUNC_IN_DONE,     0, 0,   0);
        queue_event(FUNC_OUT_RX,      0, 0,   0);
        queue_event(FUNC_SETUP,       0, 0,   0);
        queue_event(FUNC_START_WRITE, 0, 0,   64);
        queue_event(FUNC_IN_DONE,     0, 0,   0);
        queue_event(FUNC_IN_DONE,     0, 0,   0);
        queue_event(FUNC_SETUP,       3, 0,   0);
        queue_event(FUNC_ARM_READ,    0, 0,   130);
        queue_event(FUNC_OUT_RX,      0, 64,  0);
        queue_event(FUNC_OUT_RX,      0, 127, 0);
        queue_event(FUNC_OUT_RX,      0, 2,   0);
        queue_event(FUNC_IN_DONE,     0, 0,   0);
        queue_event(FUNC_SEND_STATUS, 5, 0,   0);
        queue_event(FUNC_START_WRITE, 0, 0,   0);
        queue_event(FUNC_START_WRITE, 3, 0,   16'hFFFF);
        queue_event(FUNC_IN_DONE,     3, 0,   0);
        queue_event(FUNC_ARM_READ,    3, 0,   16'hFFFF);
        queue_event(FUNC_OUT_RX,      3, 100, 0);
        queue_event(FUNC_OUT_RX,      3, 10,  0);
        queue_event(FUNC_IN_DONE,     7, 0,   0);
        queue_event(FUNC_SPARE_6,     1, 127, 16'hFFFF);
        queue_event(FUNC_SPARE_7,     6, 0,   0);
        wait_drained();

        // Random phases, each with its own idling pattern.
        for (int ph = 0; ph < 4; ph++) begin
            idle_mode = t_idle_mode'(ph);
            target    = events_made + PHASE_EVENTS;
            while (events_made < target) begin
                queue_sequence();
                // no-idle phase: long receiver hold-off while events keep coming
                if (ph == 0 && events_made > target - PHASE_EVENTS / 2 && hold_requests == 0) begin
                    hold_requests++;
                end
                // sender pause until every result is back, then a long receiver hold-off
                if (ph == 1 && events_made > target - PHASE_EVENTS / 2 && hold_requests == 1) begin
                    wait_drained();
                    hold_requests++;
                end
                while (events_to_send.size() > QUEUE_DEPTH) @(posedge i_clk);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Hard limit, far above the slowest correct run.
    initial begin
        #800000;
        $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/usbets_pkg.sv
rtl/usbets_in_if.sv
rtl/usbets_out_if.sv
rtl/usbets_step.sv
rtl/usb_endpoint_transfer_sequencer_unit.sv
tb/usb_endpoint_transfer_sequencer_unit_tb.sv
